FILE: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, off while reset is high.
`define ASSERT_CHK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_CHK_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/ewra_pkg.sv
// Shared types and constants of the exponentially weighted running average unit.
package ewra_pkg;

   localparam int STEPS = 32;
   localparam int CNT_W = $clog2(STEPS);

   localparam logic [31:0] DECAY_RESET = 32'hFFFF_0000;
   localparam logic [31:0] RATE_ONE    = 32'h0001_0000;
   localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
   localparam logic [47:0] RECIP_HEAD  = 48'h0000_0001_0000;
   localparam logic [63:0] S_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] S_MIN_CODE  = 64'h8000_0000_0000_0000;
   localparam logic signed [64:0] S_HI = 65'sh0_7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [64:0] S_LO = 65'sh1_8000_0000_0000_0001;
   localparam logic [47:0] W_MAX       = 48'hFFFF_FFFF_FFFF;

   // load starts a serial operation, step advances it by one bit
   typedef struct packed {
      logic load;
      logic step;
   } ser_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RECIP,
      ST_RECIP_END,
      ST_PREP,
      ST_MUL,
      ST_UPDATE,
      ST_ACCUM,
      ST_AVG_PREP,
      ST_AVG_DIV,
      ST_AVG_FIN,
      ST_OUT
   } state_type;

endpackage

FILE: sv/exp_weighted_running_average_unit.sv
// Top level of the exponentially weighted running average unit.
// Usage: write decay_rate (signed Q16.16) on the csr_ channel while the block
// is idle; csr_ready is always high. Send samples on the req_ channel
// (start_series, sample_value, sample_valid); each accepted word yields one
// rsp_ word with the running average and its valid flag.
// An item passes through the two-lane bit-serial multiplier and then the
// bit-serial divider that forms the average, with control and update steps
// around them. A word with start_series set and a rate above 1.0 first
// forms the reciprocal on the same divider. An invalid sample or a negative
// rate skips the multiplier; a negative rate, a zero weight sum or a
// saturated average also skips the divider.
// req_stall stays high while an item is in work; one item is in work at a time.
// The result waits in an output register; while rsp_stall holds it, the next
// item is still accepted and processed, and waits before its write-back.
// Synchronous reset sets decay_rate to -1.0, clears the sums, sets the forward
// weight to 1.0 and empties the output register.
module exp_weighted_running_average_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_start_series,
   input  logic signed [31:0] req_sample_value,
   input  logic               req_sample_valid,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_average,
   output logic               rsp_average_valid,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic signed [31:0] csr_decay_rate
);

   `include "assert_macros.svh"

   ewra_pkg::state_type state_ff, state_in;
   logic [ewra_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   logic [31:0] decay_rate_ff;
   logic [63:0] weighted_sum_ff;
   logic [47:0] weight_sum_ff;
   logic [32:0] forward_weight_ff;
   logic [31:0] reciprocal_rate_ff;

   logic signed [31:0] x_ff;
   logic               vld_ff;
   logic [63:0]        base_ff;
   logic [63:0]        addend_ff;
   logic [32:0]        waddend_ff;
   logic [32:0]        mag_ff;
   logic               avg_neg_ff;
   logic               known_ff;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_average_ff;
   logic               rsp_average_valid_ff;

   ewra_pkg::ser_ctl_type mul_ctl, div_ctl;
   logic [63:0] mul_a_mcand;
   logic [31:0] mul_a_mult;
   logic [47:0] mul_b_mcand;
   logic [31:0] mul_b_mult;
   logic [95:0] prod_a;
   logic [79:0] prod_b;
   logic [47:0] div_rem;
   logic [31:0] div_low;
   logic [47:0] div_divisor;
   logic [31:0] quot;
   logic        round_up;

   logic        accept;
   logic        cnt_last;
   logic        out_free;
   logic        rate_neg, rate_fwd, rate_back;
   logic [63:0] s_mag;
   logic [31:0] x_mag;
   logic        avg_ovf;

   logic [95:0] prod_a_rnd;
   logic [79:0] p_a;
   logic [63:0] back_mag;
   logic [63:0] back_scaled;
   logic [63:0] fwd_term;
   logic [79:0] w_rnd;
   logic [79:0] f_rnd;
   logic signed [64:0] s_sum;
   logic [63:0] s_sat;
   logic [48:0] w_sum;
   logic [47:0] w_sat;
   logic [32:0] mag_neg;
   logic [31:0] avg_word;

   assign accept    = req_valid && !req_stall;
   assign cnt_last  = (cnt_ff == ewra_pkg::CNT_W'(ewra_pkg::STEPS - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign rate_neg  = decay_rate_ff[31];
   assign rate_fwd  = !rate_neg && (decay_rate_ff > ewra_pkg::RATE_ONE);
   assign rate_back = !rate_neg && !rate_fwd;

   assign s_mag   = weighted_sum_ff[63] ? (~weighted_sum_ff + 64'd1) : weighted_sum_ff;
   assign x_mag   = x_ff[31] ? (~x_ff + 32'd1) : x_ff;
   assign avg_ovf = (s_mag[63:16] >= weight_sum_ff);

   // update arithmetic on the finished products
   assign prod_a_rnd  = prod_a + 96'h8000;
   assign p_a         = prod_a_rnd[95:16];
   assign back_mag    = (|p_a[79:63]) ? ewra_pkg::S_MAX : p_a[63:0];
   assign back_scaled = weighted_sum_ff[63] ? (~back_mag + 64'd1) : back_mag;
   assign fwd_term    = x_ff[31] ? (~p_a[63:0] + 64'd1) : p_a[63:0];
   assign w_rnd       = prod_b + 80'h8000;
   assign f_rnd       = prod_b + 80'h8000_0000;

   // saturating accumulation
   assign s_sum = $signed({base_ff[63], base_ff}) + $signed({addend_ff[63], addend_ff});
   always_comb begin
      if (s_sum > ewra_pkg::S_HI) begin
         s_sat = ewra_pkg::S_MAX;
      end else if (s_sum < ewra_pkg::S_LO) begin
         s_sat = ewra_pkg::S_LO[63:0];
      end else begin
         s_sat = s_sum[63:0];
      end
   end
   assign w_sum = {1'b0, weight_sum_ff} + {16'd0, waddend_ff};
   assign w_sat = w_sum[48] ? ewra_pkg::W_MAX : w_sum[47:0];

   // saturate the signed average to the 32-bit signed range, zero when unknown
   assign mag_neg = ~mag_ff + 33'd1;
   always_comb begin
      if (!known_ff) begin
         avg_word = 32'd0;
      end else if (avg_neg_ff) begin
         avg_word = (mag_ff > 33'h0_8000_0000) ? 32'h8000_0000 : mag_neg[31:0];
      end else begin
         avg_word = (mag_ff > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag_ff[31:0];
      end
   end

   // operand selection for the serial units
   always_comb begin
      if (rate_back) begin
         mul_a_mcand = s_mag;
         mul_a_mult  = decay_rate_ff;
         mul_b_mcand = weight_sum_ff;
         mul_b_mult  = decay_rate_ff;
      end else begin
         mul_a_mcand = {31'd0, forward_weight_ff};
         mul_a_mult  = x_mag;
         mul_b_mcand = {15'd0, forward_weight_ff};
         mul_b_mult  = reciprocal_rate_ff;
      end
      if (state_ff == ewra_pkg::ST_IDLE) begin
         div_rem     = ewra_pkg::RECIP_HEAD;
         div_low     = {1'b0, decay_rate_ff[31:1]};
         div_divisor = {16'd0, decay_rate_ff};
      end else begin
         div_rem     = s_mag[63:16];
         div_low     = {s_mag[15:0], 16'd0};
         div_divisor = weight_sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ewra_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      mul_ctl   = '0;
      div_ctl   = '0;
      unique case (state_ff)
         ewra_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_start_series && rate_fwd) begin
                  div_ctl.load = 1'b1;
                  state_in     = ewra_pkg::ST_RECIP;
               end else begin
                  state_in = ewra_pkg::ST_PREP;
               end
            end
         end
         ewra_pkg::ST_RECIP: begin
            div_ctl.step = 1'b1;
            if (cnt_last) begin
               state_in = ewra_pkg::ST_RECIP_END;
            end
         end
         ewra_pkg::ST_RECIP_END: begin
            state_in = ewra_pkg::ST_PREP;
         end
         ewra_pkg::ST_PREP: begin
            if (rate_neg || !vld_ff) begin
               state_in = ewra_pkg::ST_AVG_PREP;
            end else begin
               mul_ctl.load = 1'b1;
               state_in     = ewra_pkg::ST_MUL;
            end
         end
         ewra_pkg::ST_MUL: begin
            mul_ctl.step = 1'b1;
            if (cnt_last) begin
               state_in = ewra_pkg::ST_UPDATE;
            end
         end
         ewra_pkg::ST_UPDATE: begin
            state_in = ewra_pkg::ST_ACCUM;
         end
         ewra_pkg::ST_ACCUM: begin
            state_in = ewra_pkg::ST_AVG_PREP;
         end
         ewra_pkg::ST_AVG_PREP: begin
            if (rate_neg || weight_sum_ff == 48'd0 || avg_ovf) begin
               state_in = ewra_pkg::ST_OUT;
            end else begin
               div_ctl.load = 1'b1;
               state_in     = ewra_pkg::ST_AVG_DIV;
            end
         end
         ewra_pkg::ST_AVG_DIV: begin
            div_ctl.step = 1'b1;
            if (cnt_last) begin
               state_in = ewra_pkg::ST_AVG_FIN;
            end
         end
         ewra_pkg::ST_AVG_FIN: begin
            state_in = ewra_pkg::ST_OUT;
         end
         ewra_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = ewra_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ewra_pkg::ST_IDLE;
         end
      endcase
      cnt_in = (mul_ctl.step || div_ctl.step) ? cnt_ff + 1'b1 : '0;
   end

   // architectural state and output handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_rate_ff      <= ewra_pkg::DECAY_RESET;
         weighted_sum_ff    <= '0;
         weight_sum_ff      <= '0;
         forward_weight_ff  <= ewra_pkg::ONE_Q32;
         reciprocal_rate_ff <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            decay_rate_ff <= csr_decay_rate;
         end
         if (accept && req_start_series) begin
            weighted_sum_ff   <= '0;
            weight_sum_ff     <= '0;
            forward_weight_ff <= ewra_pkg::ONE_Q32;
            if (!rate_fwd) begin
               reciprocal_rate_ff <= '0;
            end
         end
         if (state_ff == ewra_pkg::ST_RECIP_END) begin
            reciprocal_rate_ff <= quot;
         end
         if (state_ff == ewra_pkg::ST_UPDATE) begin
            if (rate_back) begin
               weight_sum_ff <= w_rnd[63:16];
            end else begin
               forward_weight_ff <= f_rnd[64:32];
            end
         end
         if (state_ff == ewra_pkg::ST_ACCUM) begin
            weighted_sum_ff <= s_sat;
            weight_sum_ff   <= w_sat;
         end
         if (state_ff == ewra_pkg::ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers and output word
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff   <= req_sample_value;
         vld_ff <= req_sample_valid;
      end
      if (state_ff == ewra_pkg::ST_UPDATE) begin
         if (rate_back) begin
            base_ff    <= back_scaled;
            addend_ff  <= {{16{x_ff[31]}}, x_ff, 16'd0};
            waddend_ff <= ewra_pkg::ONE_Q32;
         end else begin
            base_ff    <= weighted_sum_ff;
            addend_ff  <= fwd_term;
            waddend_ff <= forward_weight_ff;
         end
      end
      if (state_ff == ewra_pkg::ST_AVG_PREP) begin
         known_ff   <= !rate_neg && (weight_sum_ff != 48'd0);
         avg_neg_ff <= weighted_sum_ff[63];
         mag_ff     <= ewra_pkg::ONE_Q32;
      end
      if (state_ff == ewra_pkg::ST_AVG_FIN) begin
         mag_ff <= {1'b0, quot} + {32'd0, round_up};
      end
      if (state_ff == ewra_pkg::ST_OUT && out_free) begin
         rsp_average_ff       <= avg_word;
         rsp_average_valid_ff <= known_ff;
      end
   end

   ewra_mul u_mul (
      .clock        (clock),
      .ctl          (mul_ctl),
      .load_a_mcand (mul_a_mcand),
      .load_a_mult  (mul_a_mult),
      .load_b_mcand (mul_b_mcand),
      .load_b_mult  (mul_b_mult),
      .prod_a       (prod_a),
      .prod_b       (prod_b)
   );

   ewra_div u_div (
      .clock        (clock),
      .ctl          (div_ctl),
      .load_rem     (div_rem),
      .load_low     (div_low),
      .load_divisor (div_divisor),
      .quot         (quot),
      .round_up     (round_up)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_average       = rsp_average_ff;
   assign rsp_average_valid = rsp_average_valid_ff;

   `ASSERT_CHK(a_busy_after_accept, clock, reset, accept |=> req_stall, "accept not followed by stall")
   `ASSERT_CHK(a_unknown_is_zero, clock, reset, (rsp_valid && !rsp_average_valid) |-> (rsp_average == 32'sd0), "unknown average not zero")
   `ASSERT_CHK(a_fwd_weight_range, clock, reset, forward_weight_ff <= ewra_pkg::ONE_Q32, "forward weight above one")
   `ASSERT_CHK(a_sum_range, clock, reset, weighted_sum_ff != ewra_pkg::S_MIN_CODE, "weighted sum outside saturation range")

endmodule

FILE: sv/ewra_mul.sv
// Two-lane shift-add multiplier, one multiplier bit per cycle in each lane while step is set.
module ewra_mul (
   input  logic                 clock,
   input  ewra_pkg::ser_ctl_type ctl,
   input  logic [63:0]          load_a_mcand,
   input  logic [31:0]          load_a_mult,
   input  logic [47:0]          load_b_mcand,
   input  logic [31:0]          load_b_mult,
   output logic [95:0]          prod_a,
   output logic [79:0]          prod_b
);

   logic [63:0] a_mcand_ff;
   logic [95:0] a_prod_ff;
   logic [47:0] b_mcand_ff;
   logic [79:0] b_prod_ff;
   logic [64:0] a_sum;
   logic [48:0] b_sum;

   // add the multiplicand into the upper half when the low bit is set
   assign a_sum = {1'b0, a_prod_ff[95:32]} + (a_prod_ff[0] ? {1'b0, a_mcand_ff} : 65'd0);
   assign b_sum = {1'b0, b_prod_ff[79:32]} + (b_prod_ff[0] ? {1'b0, b_mcand_ff} : 49'd0);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         a_mcand_ff <= load_a_mcand;
         a_prod_ff  <= {64'd0, load_a_mult};
         b_mcand_ff <= load_b_mcand;
         b_prod_ff  <= {48'd0, load_b_mult};
      end else if (ctl.step) begin
         a_prod_ff <= {a_sum, a_prod_ff[31:1]};
         b_prod_ff <= {b_sum, b_prod_ff[31:1]};
      end
   end

   assign prod_a = a_prod_ff;
   assign prod_b = b_prod_ff;

endmodule

FILE: sv/ewra_div.sv
// Restoring divider, one quotient bit per cycle while step is set, 32-bit quotient.
module ewra_div (
   input  logic                 clock,
   input  ewra_pkg::ser_ctl_type ctl,
   input  logic [47:0]          load_rem,
   input  logic [31:0]          load_low,
   input  logic [47:0]          load_divisor,
   output logic [31:0]          quot,
   output logic                 round_up
);

   logic [47:0] rem_ff;
   logic [31:0] low_ff;
   logic [47:0] divisor_ff;
   logic [48:0] trial;
   logic [48:0] diff;
   logic        q_bit;

   // shift the next dividend bit in and try the subtraction
   assign trial = {rem_ff, low_ff[31]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign q_bit = (trial >= {1'b0, divisor_ff});

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         rem_ff     <= load_rem;
         low_ff     <= load_low;
         divisor_ff <= load_divisor;
      end else if (ctl.step) begin
         rem_ff <= q_bit ? diff[47:0] : trial[47:0];
         low_ff <= {low_ff[30:0], q_bit};
      end
   end

   assign quot     = low_ff;
   assign round_up = ({rem_ff, 1'b0} >= {1'b0, divisor_ff});

endmodule
